// ===== rtl/core/sd128_pkg.sv =====
package sd128_pkg;

  localparam int unsigned HalfW  = 64;
  localparam int unsigned FullW  = 2 * HalfW;
  localparam int unsigned StepW  = $clog2(FullW);
  localparam logic [StepW-1:0] LastStep = StepW'(FullW - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } sd_state_t;

  typedef struct packed {
    logic load;
    logic mag;
    logic step;
    logic fix;
    logic out_load;
  } sd_cmd_t;

  typedef struct packed {
    logic div_zero;
  } sd_stat_t;

endpackage

// ===== rtl/core/sd128_dp.sv =====
module sd128_dp
  import sd128_pkg::*;
(
  input  logic                    clk,
  input  sd_cmd_t                 cmd,
  output sd_stat_t                stat,
  input  logic signed [HalfW-1:0] in_dividend_high,
  input  logic        [HalfW-1:0] in_dividend_low,
  input  logic signed [HalfW-1:0] in_divisor_high,
  input  logic        [HalfW-1:0] in_divisor_low,
  output logic signed [HalfW-1:0] out_quotient_high,
  output logic        [HalfW-1:0] out_quotient_low,
  output logic signed [HalfW-1:0] out_remainder_high,
  output logic        [HalfW-1:0] out_remainder_low,
  output logic                    out_status
);

  // num_r holds the dividend and fills with quotient bits as the steps go
  logic [FullW-1:0] num_r, num_nxt;
  logic [FullW-1:0] den_r, den_nxt;
  logic [FullW-1:0] rem_r, rem_nxt;
  logic             nneg_r, nneg_nxt;
  logic             dneg_r, dneg_nxt;
  logic             dz_r, dz_nxt;
  logic [FullW-1:0] quo_out_r, quo_out_nxt;
  logic [FullW-1:0] rem_out_r, rem_out_nxt;
  logic             status_r, status_nxt;

  logic [FullW-1:0] rem_sh;
  logic [FullW:0]   diff;
  logic [FullW-1:0] num_neg;
  logic [FullW-1:0] den_neg;
  logic [FullW-1:0] rem_neg;
  logic [FullW-1:0] in_num;
  logic [FullW-1:0] in_den;

  assign in_num  = {in_dividend_high, in_dividend_low};
  assign in_den  = {in_divisor_high, in_divisor_low};
  assign num_neg = ~num_r + FullW'(1);
  assign den_neg = ~den_r + FullW'(1);
  assign rem_neg = ~rem_r + FullW'(1);
  assign rem_sh  = {rem_r[FullW-2:0], num_r[FullW-1]};
  assign diff    = {1'b0, rem_sh} - {1'b0, den_r};

  always_comb begin
    num_nxt     = num_r;
    den_nxt     = den_r;
    rem_nxt     = rem_r;
    nneg_nxt    = nneg_r;
    dneg_nxt    = dneg_r;
    dz_nxt      = dz_r;
    quo_out_nxt = quo_out_r;
    rem_out_nxt = rem_out_r;
    status_nxt  = status_r;
    if (cmd.load) begin
      num_nxt  = in_num;
      den_nxt  = in_den;
      rem_nxt  = '0;
      nneg_nxt = in_num[FullW-1];
      dneg_nxt = in_den[FullW-1];
      dz_nxt   = (in_den == '0);
    end
    if (cmd.mag) begin
      num_nxt = nneg_r ? num_neg : num_r;
      den_nxt = dneg_r ? den_neg : den_r;
    end
    if (cmd.step) begin
      // restoring step: keep the difference when no borrow
      if (!diff[FullW]) begin
        rem_nxt = diff[FullW-1:0];
      end else begin
        rem_nxt = rem_sh;
      end
      num_nxt = {num_r[FullW-2:0], ~diff[FullW]};
    end
    if (cmd.fix) begin
      num_nxt = (nneg_r ^ dneg_r) ? num_neg : num_r;
      rem_nxt = nneg_r ? rem_neg : rem_r;
    end
    if (cmd.out_load) begin
      if (dz_r) begin
        quo_out_nxt = '0;
        rem_out_nxt = '0;
      end else begin
        quo_out_nxt = num_r;
        rem_out_nxt = rem_r;
      end
      status_nxt = dz_r;
    end
  end

  always_ff @(posedge clk) begin
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    rem_r     <= rem_nxt;
    nneg_r    <= nneg_nxt;
    dneg_r    <= dneg_nxt;
    dz_r      <= dz_nxt;
    quo_out_r <= quo_out_nxt;
    rem_out_r <= rem_out_nxt;
    status_r  <= status_nxt;
  end

  assign stat.div_zero      = dz_r;
  assign out_quotient_high  = $signed(quo_out_r[FullW-1:HalfW]);
  assign out_quotient_low   = quo_out_r[HalfW-1:0];
  assign out_remainder_high = $signed(rem_out_r[FullW-1:HalfW]);
  assign out_remainder_low  = rem_out_r[HalfW-1:0];
  assign out_status         = status_r;

endmodule

// ===== rtl/core/sd128_ctrl.sv =====
module sd128_ctrl
  import sd128_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  sd_stat_t stat,
  output sd_cmd_t  cmd
);

  sd_state_t        state_r, state_nxt;
  logic [StepW-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.mag   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = stat.div_zero ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + StepW'(1);
        if (cnt_r == LastStep) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside done state");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PREP && !stat.div_zero) |=> (state_r == ST_DIV && cnt_r == '0))
    else $error("division did not start at step zero");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r == LastStep) |=> state_r == ST_FIX)
    else $error("division did not end after last step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.out_load)
    else $error("held result overwritten");
`endif

endmodule

// ===== rtl/core/signed_divide_128.sv =====
// Signed 128-bit divider, restoring radix-2, one quotient bit per cycle.
// A request is loaded, turned to magnitudes, run through the 128-step subtract loop,
// sign-fixed and written to the output registers; a zero divisor skips the loop and fix.
// A new request is taken only after the last result is loaded into the output registers.
// Reset clears the controller and output valid; datapath registers are not reset.
module signed_divide_128
  import sd128_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [HalfW-1:0] in_dividend_high,
  input  logic        [HalfW-1:0] in_dividend_low,
  input  logic signed [HalfW-1:0] in_divisor_high,
  input  logic        [HalfW-1:0] in_divisor_low,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [HalfW-1:0] out_quotient_high,
  output logic        [HalfW-1:0] out_quotient_low,
  output logic signed [HalfW-1:0] out_remainder_high,
  output logic        [HalfW-1:0] out_remainder_low,
  output logic                    out_status
);

  sd_cmd_t  cmd;
  sd_stat_t stat;

  sd128_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sd128_dp u_dp (
    .clk                (clk),
    .cmd                (cmd),
    .stat               (stat),
    .in_dividend_high   (in_dividend_high),
    .in_dividend_low    (in_dividend_low),
    .in_divisor_high    (in_divisor_high),
    .in_divisor_low     (in_divisor_low),
    .out_quotient_high  (out_quotient_high),
    .out_quotient_low   (out_quotient_low),
    .out_remainder_high (out_remainder_high),
    .out_remainder_low  (out_remainder_low),
    .out_status         (out_status)
  );

endmodule
